// ----- hdl/lla_pkg.sv -----
// Shared types and constants for the life-like automaton step block.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package lla_pkg;

   localparam int GRID_MAX   = 32;
   localparam int WIN_DEPTH  = 2 * GRID_MAX + 2;
   localparam int WIN_IDX_W  = $clog2(WIN_DEPTH);
   localparam int SIZE_W     = 6;
   localparam int POS_W      = 5;
   localparam int MASK_W     = 9;
   localparam int LIVE_W     = 4;
   localparam int NBR_N      = 8;
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int ADDR_W     = 4;
   localparam int DATA_W     = 32;
   localparam int MIN_SIZE   = 3;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_SIDE_LEN     = 2'd0;
   localparam logic [1:0] REG_BIRTH_MASK   = 2'd1;
   localparam logic [1:0] REG_SURVIVE_MASK = 2'd2;

   localparam logic [SIZE_W-1:0] SIDE_LEN_RST     = SIZE_W'(32);
   localparam logic [MASK_W-1:0] BIRTH_MASK_RST   = MASK_W'(8);
   localparam logic [MASK_W-1:0] SURVIVE_MASK_RST = MASK_W'(12);

   typedef struct packed {
      logic [SIZE_W-1:0] side_len;
      logic [MASK_W-1:0] birth_mask;
      logic [MASK_W-1:0] survive_mask;
   } cfg_type;

   // one accepted request after the window: position, neighbors, flags
   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             arriving;
      logic             self_cell;
      logic [NBR_N-1:0] nbr;
      logic             interior;
      logic             border;
      logic             frame_last;
   } stage_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             alive;
      logic             frame_last;
   } result_type;

endpackage

// ----- hdl/lla_if.sv -----
// Valid/ready channel interfaces for the request and response streams.
// Depends on lla_pkg for field widths.
interface lla_req_if;
   logic valid;
   logic ready;
   logic cell_in;

   modport source (output valid, output cell_in, input ready);
   modport sink   (input valid, input cell_in, output ready);
endinterface

interface lla_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [lla_pkg::POS_W-1:0] out_row;
   logic [lla_pkg::POS_W-1:0] out_col;
   logic                     cell_out;
   logic                     frame_last;

   modport source (output valid, output out_row, output out_col, output cell_out,
                   output frame_last, input ready);
   modport sink   (input valid, input out_row, input out_col, input cell_out,
                   input frame_last, output ready);
endinterface

// ----- hdl/lla_csr.sv -----
// APB-style configuration registers: side length, birth mask, survive mask.
// Depends on lla_pkg.
module lla_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lla_pkg::ADDR_W-1:0]  paddr,
   input  logic [lla_pkg::DATA_W-1:0]  pwdata,
   output logic [lla_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output lla_pkg::cfg_type            cfg
);

   lla_pkg::cfg_type cfg_ff;
   lla_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [1:0]       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            lla_pkg::REG_SIDE_LEN:     cfg_in.side_len     = pwdata[lla_pkg::SIZE_W-1:0];
            lla_pkg::REG_BIRTH_MASK:   cfg_in.birth_mask   = pwdata[lla_pkg::MASK_W-1:0];
            lla_pkg::REG_SURVIVE_MASK: cfg_in.survive_mask = pwdata[lla_pkg::MASK_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.side_len     <= lla_pkg::SIDE_LEN_RST;
         cfg_ff.birth_mask   <= lla_pkg::BIRTH_MASK_RST;
         cfg_ff.survive_mask <= lla_pkg::SURVIVE_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         lla_pkg::REG_SIDE_LEN:     prdata = lla_pkg::DATA_W'(cfg_ff.side_len);
         lla_pkg::REG_BIRTH_MASK:   prdata = lla_pkg::DATA_W'(cfg_ff.birth_mask);
         lla_pkg::REG_SURVIVE_MASK: prdata = lla_pkg::DATA_W'(cfg_ff.survive_mask);
         default:                   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- hdl/lla_window.sv -----
// Raster position counters, two-row shift window and the input stage register.
// Depends on lla_pkg and lla_req_if.
module lla_window (
   input  logic                         clock,
   input  logic                         reset,
   lla_req_if.sink                      req_if,
   input  logic [lla_pkg::SIZE_W-1:0]   side_len,
   input  logic                         stage_ready,
   output logic                         stage_valid,
   output lla_pkg::stage_type           stage
);

   logic [lla_pkg::WIN_DEPTH-1:0] win_ff;
   logic [lla_pkg::WIN_DEPTH-1:0] win_in;
   logic [lla_pkg::POS_W-1:0]     row_ff, row_in;
   logic [lla_pkg::POS_W-1:0]     col_ff, col_in;
   logic                          valid_ff, valid_in;
   lla_pkg::stage_type            stage_ff, stage_in;

   logic [lla_pkg::SIZE_W-1:0]    size_n;
   logic [lla_pkg::SIZE_W-1:0]    last_idx;
   logic [lla_pkg::SIZE_W-1:0]    row_x, col_x;
   logic [lla_pkg::WIN_IDX_W-1:0] base_one, base_two;
   logic [2:0]                    tap_one, tap_two;
   logic                          row_end, col_end;
   logic                          accept;

   // clamp size to the supported range
   always_comb begin
      if (side_len < lla_pkg::SIZE_W'(lla_pkg::MIN_SIZE)) begin
         size_n = lla_pkg::SIZE_W'(lla_pkg::MIN_SIZE);
      end else if (side_len > lla_pkg::SIZE_W'(lla_pkg::GRID_MAX)) begin
         size_n = lla_pkg::SIZE_W'(lla_pkg::GRID_MAX);
      end else begin
         size_n = side_len;
      end
   end

   assign last_idx = size_n - lla_pkg::SIZE_W'(1);
   assign row_x    = lla_pkg::SIZE_W'(row_ff);
   assign col_x    = lla_pkg::SIZE_W'(col_ff);
   assign row_end  = row_x >= last_idx;
   assign col_end  = col_x >= last_idx;

   // win_ff[d-1] is the cell that arrived d requests ago
   assign base_one = lla_pkg::WIN_IDX_W'(size_n) - lla_pkg::WIN_IDX_W'(1);
   assign base_two = (lla_pkg::WIN_IDX_W'(size_n) << 1) - lla_pkg::WIN_IDX_W'(1);
   assign tap_one  = win_ff[base_one +: 3];
   assign tap_two  = win_ff[base_two +: 3];

   assign req_if.ready = ~valid_ff | stage_ready;
   assign accept       = req_if.valid & req_if.ready;

   always_comb begin
      stage_in            = stage_ff;
      win_in              = win_ff;
      row_in              = row_ff;
      col_in              = col_ff;
      valid_in            = valid_ff & ~stage_ready;
      if (accept) begin
         valid_in            = 1'b1;
         stage_in.row        = row_ff;
         stage_in.col        = col_ff;
         stage_in.arriving   = req_if.cell_in;
         stage_in.self_cell  = tap_one[1];
         stage_in.nbr        = {tap_two, tap_one[2], tap_one[0], win_ff[1:0], req_if.cell_in};
         stage_in.interior   = (row_x >= lla_pkg::SIZE_W'(2)) && (row_x <= last_idx) &&
                               (col_x >= lla_pkg::SIZE_W'(2)) && (col_x <= last_idx);
         stage_in.border     = (row_ff == '0) || row_end || (col_ff == '0) || col_end;
         stage_in.frame_last = row_end & col_end;
         win_in              = {win_ff[lla_pkg::WIN_DEPTH-2:0], req_if.cell_in};
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_ff + lla_pkg::POS_W'(1);
         end else begin
            col_in = col_ff + lla_pkg::POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         row_ff   <= '0;
         col_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         win_ff   <= win_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
   end

   assign stage_valid = valid_ff;
   assign stage       = stage_ff;

endmodule

// ----- hdl/lla_result.sv -----
// Neighbor count, birth/survive rule and the 32-entry response queue.
// Depends on lla_pkg and lla_rsp_if.
module lla_result (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stage_valid,
   input  lla_pkg::stage_type          stage,
   input  logic [lla_pkg::MASK_W-1:0]  birth_mask,
   input  logic [lla_pkg::MASK_W-1:0]  survive_mask,
   output logic                        stage_ready,
   lla_rsp_if.source                   rsp_if
);

   lla_pkg::result_type         fifo_mem [lla_pkg::FIFO_DEPTH];
   logic [lla_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [lla_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [lla_pkg::FIFO_AW:0]   count_ff, count_in;
   logic [lla_pkg::FIFO_AW-1:0] wr_next;
   logic [lla_pkg::LIVE_W-1:0]  live;
   logic                        next_cell;
   lla_pkg::result_type         inner_res, border_res, first_res;
   logic                        push, pop, any_res, two_res;
   logic [1:0]                  n_push;

   always_comb begin
      live = '0;
      for (int i = 0; i < lla_pkg::NBR_N; i++) begin
         live = live + lla_pkg::LIVE_W'(stage.nbr[i]);
      end
   end

   assign next_cell = stage.self_cell ? survive_mask[live] : birth_mask[live];

   assign inner_res.row        = stage.row - lla_pkg::POS_W'(1);
   assign inner_res.col        = stage.col - lla_pkg::POS_W'(1);
   assign inner_res.alive      = next_cell;
   assign inner_res.frame_last = 1'b0;

   assign border_res.row        = stage.row;
   assign border_res.col        = stage.col;
   assign border_res.alive      = stage.arriving;
   assign border_res.frame_last = stage.frame_last;

   assign first_res = stage.interior ? inner_res : border_res;

   // room for two entries is always kept before a stage is taken
   assign stage_ready = count_ff <= (lla_pkg::FIFO_AW + 1)'(lla_pkg::FIFO_DEPTH - 2);
   assign push        = stage_valid & stage_ready;
   assign any_res     = stage.interior | stage.border;
   assign two_res     = stage.interior & stage.border;
   assign n_push      = push ? ({1'b0, stage.interior} + {1'b0, stage.border}) : 2'd0;
   assign pop         = rsp_if.valid & rsp_if.ready;
   assign wr_next     = wr_ptr_ff + lla_pkg::FIFO_AW'(1);

   assign wr_ptr_in = wr_ptr_ff + lla_pkg::FIFO_AW'(n_push);
   assign rd_ptr_in = rd_ptr_ff + lla_pkg::FIFO_AW'(pop);
   assign count_in  = count_ff + (lla_pkg::FIFO_AW + 1)'(n_push)
                      - (lla_pkg::FIFO_AW + 1)'(pop);

   always_ff @(posedge clock) begin
      if (push & any_res) begin
         fifo_mem[wr_ptr_ff] <= first_res;
      end
      if (push & two_res) begin
         fifo_mem[wr_next] <= border_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_if.valid      = count_ff != '0;
   assign rsp_if.out_row    = fifo_mem[rd_ptr_ff].row;
   assign rsp_if.out_col    = fifo_mem[rd_ptr_ff].col;
   assign rsp_if.cell_out   = fifo_mem[rd_ptr_ff].alive;
   assign rsp_if.frame_last = fifo_mem[rd_ptr_ff].frame_last;

endmodule

// ----- hdl/life_like_automaton_step_top.sv -----
// One generation of a life-like cellular automaton on a square grid (3 to 32
// cells a side) that streams through in raster order, one cell per request.
// Border cells come back unchanged, through the stage register and the queue;
// an interior cell comes back once the cell diagonally below-right of it has
// arrived, and the bottom-right request of a frame carries frame_last and
// closes the frame. A request is taken every clock while the response queue
// has room. The rule itself is one register-to-register pass: a 66-bit shift
// window with taps set by the side length, an 8-input neighbor count and a mask
// bit select. Responses leave through a 32-entry queue, one per clock while the
// response side is ready. Every cell yields one response, but the second row
// yields few and the last row up to two per request; the queue absorbs that
// swing, so a continuous stream runs at one request per clock up to 30 cells a
// side. At 31 and 32 cells a side the last row's surplus reaches the queue's
// two-entry reserve and requests stall in each frame. The last row leaves up
// to n responses queued, which drain after its last request. A stalled
// response side stalls requests once the queue holds 31 entries.
// Configuration (side length at 0x0, birth_mask at 0x4, survive_mask at 0x8)
// is written while no frame is in flight; pready is tied high and reads return
// the register values.
// Depends on lla_pkg, lla_if, lla_csr, lla_window and lla_result.
module life_like_automaton_step_top (
   input  logic                        clock,
   input  logic                        reset,
   lla_req_if.sink                     req_if,
   lla_rsp_if.source                   rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [lla_pkg::ADDR_W-1:0]  paddr,
   input  logic [lla_pkg::DATA_W-1:0]  pwdata,
   output logic [lla_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   lla_pkg::cfg_type   cfg;
   lla_pkg::stage_type stage;
   logic               stage_valid;
   logic               stage_ready;

   // configuration registers
   lla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // input side: position counters, shift window, stage register
   lla_window u_window (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .side_len    (cfg.side_len),
      .stage_ready (stage_ready),
      .stage_valid (stage_valid),
      .stage       (stage)
   );

   // rule evaluation and response queue
   lla_result u_result (
      .clock        (clock),
      .reset        (reset),
      .stage_valid  (stage_valid),
      .stage        (stage),
      .birth_mask   (cfg.birth_mask),
      .survive_mask (cfg.survive_mask),
      .stage_ready  (stage_ready),
      .rsp_if       (rsp_if)
   );

endmodule

// ----- hdl/lla_checker.sv -----
// Port-level checks for the automaton step block, bound to the top level.
// Depends on lla_pkg; attached to life_like_automaton_step_top by the bind below.
module lla_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [lla_pkg::POS_W-1:0]   out_row,
   input logic [lla_pkg::POS_W-1:0]   out_col,
   input logic                        cell_out,
   input logic                        frame_last
);

   // nothing left in the queue after reset
   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // the input stage is free after reset
   a_rst_ready: assert property (@(posedge clock) reset |=> req_ready)
      else $error("request not ready right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({out_row, out_col, cell_out, frame_last}))
      else $error("response payload changed while stalled");

endmodule

bind life_like_automaton_step_top lla_checker u_lla_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .out_row    (rsp_if.out_row),
   .out_col    (rsp_if.out_col),
   .cell_out   (rsp_if.cell_out),
   .frame_last (rsp_if.frame_last)
);
